FILE: rtl/tppa_pkg.sv
// ----------------------------------------------------------------------------
// Three-phase power accumulator: shared package
// Constants, sample and result types and the product helpers, imported by all
// modules of the block.
// ----------------------------------------------------------------------------
package tppa_pkg;

  localparam int SAMPLES_PER_CYCLE = 1024;
  localparam int QUARTER_DELAY     = 256;
  localparam int RESULT_SHIFT      = 10;

  localparam int NUM_PHASES = 3;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int SQ_OUT_W   = 31;
  localparam int PWR_OUT_W  = 32;
  localparam int PHASE_W    = 2;
  localparam int POS_W      = $clog2(SAMPLES_PER_CYCLE);
  localparam int DLY_AW     = $clog2(QUARTER_DELAY);
  // Keep every bit that reaches an output field; higher bits are never seen.
  localparam int ACC_W      = RESULT_SHIFT + PWR_OUT_W;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_NUM_REGS = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CURRENT_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_VOLTAGE_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CURRENT_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_VOLTAGE_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CURRENT_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_VOLTAGE_C = 3'd5;

  localparam logic [PHASE_W-1:0]  LAST_PHASE = PHASE_W'(NUM_PHASES - 1);
  localparam logic [POS_W-1:0]    LAST_POS   = POS_W'(SAMPLES_PER_CYCLE - 1);
  localparam logic [DLY_AW-1:0]   LAST_PTR   = DLY_AW'(QUARTER_DELAY - 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    sample_t i;
    sample_t u;
  } phase_smp_t;

  typedef struct packed {
    logic                        valid;
    logic                        last;
    logic                        primed;
  } s1_ctrl_t;

  typedef struct packed {
    logic [SQ_OUT_W-1:0]         cur_sq;
    logic [SQ_OUT_W-1:0]         volt_sq;
    logic signed [PWR_OUT_W-1:0] act;
    logic signed [PWR_OUT_W-1:0] react;
  } phase_res_t;

  function automatic prod_t mul16(input sample_t a, input sample_t b);
    prod_t ea;
    prod_t eb;
    ea = PROD_W'(a);
    eb = PROD_W'(b);
    return ea * eb;
  endfunction

  function automatic acc_t sext_prod(input prod_t p);
    return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

FILE: rtl/tppa_if.sv
// ----------------------------------------------------------------------------
// Three-phase power accumulator: channel interfaces
// Sample input channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface tppa_in_if import tppa_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t current_a;
  sample_t voltage_a;
  sample_t current_b;
  sample_t voltage_b;
  sample_t current_c;
  sample_t voltage_c;

  modport source (output valid, current_a, voltage_a, current_b, voltage_b,
                  current_c, voltage_c, input ready);
  modport sink   (input valid, current_a, voltage_a, current_b, voltage_b,
                  current_c, voltage_c, output ready);
endinterface

interface tppa_out_if import tppa_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [PHASE_W-1:0]          phase_index;
  logic [SQ_OUT_W-1:0]         current_square_sum;
  logic [SQ_OUT_W-1:0]         voltage_square_sum;
  logic signed [PWR_OUT_W-1:0] active_power_sum;
  logic signed [PWR_OUT_W-1:0] reactive_power_sum;
  logic                        last_of_cycle;

  modport source (output valid, phase_index, current_square_sum, voltage_square_sum,
                  active_power_sum, reactive_power_sum, last_of_cycle, input ready);
  modport sink   (input valid, phase_index, current_square_sum, voltage_square_sum,
                  active_power_sum, reactive_power_sum, last_of_cycle, output ready);
endinterface

interface tppa_cfg_if import tppa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SAMPLE_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tppa_delay_mem.sv
// ----------------------------------------------------------------------------
// Three-phase power accumulator: voltage delay memory
// One row per delay slot holding the three phase voltages. Read-first:
// the row read returns the value from a quarter cycle back.
// ----------------------------------------------------------------------------
module tppa_delay_mem import tppa_pkg::*; (
  input  logic                           clk,
  input  logic                           en,
  input  logic [DLY_AW-1:0]              addr,
  input  logic [NUM_PHASES*SAMPLE_W-1:0] wdata,
  output logic [NUM_PHASES*SAMPLE_W-1:0] rdata_r
);

  logic [NUM_PHASES*SAMPLE_W-1:0] mem [QUARTER_DELAY];

  always_ff @(posedge clk) begin
    if (en) begin
      mem[addr] <= wdata;
      rdata_r   <= mem[addr];
    end
  end

endmodule

FILE: rtl/tppa_mac.sv
// ----------------------------------------------------------------------------
// Three-phase power accumulator: multiply-accumulate
// Forms the twelve products of one item, then adds them into the per-phase
// sums. On the item that closes a cycle the final sums are handed out and
// the sums clear.
// ----------------------------------------------------------------------------
module tppa_mac import tppa_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  s1_ctrl_t                       s1_ctrl,
  input  phase_smp_t [NUM_PHASES-1:0]    s1_smp,
  input  logic [NUM_PHASES*SAMPLE_W-1:0] dly_rdata,
  output logic                           res_valid,
  output phase_res_t [NUM_PHASES-1:0]    res
);

  prod_t [NUM_PHASES-1:0][3:0] prod_r;
  prod_t [NUM_PHASES-1:0][3:0] prod_nxt;
  logic                        s2_valid_r;
  logic                        s2_last_r;
  acc_t  [NUM_PHASES-1:0][3:0] acc_r;
  acc_t  [NUM_PHASES-1:0][3:0] sum_nxt;
  sample_t                     ud;

  always_comb begin
    for (int p = 0; p < NUM_PHASES; p++) begin
      // Delayed voltage reads zero until the line has been filled once.
      ud = s1_ctrl.primed ? sample_t'(dly_rdata[p*SAMPLE_W +: SAMPLE_W]) : '0;
      prod_nxt[p][0] = mul16(s1_smp[p].i, s1_smp[p].i);
      prod_nxt[p][1] = mul16(s1_smp[p].u, s1_smp[p].u);
      prod_nxt[p][2] = mul16(s1_smp[p].i, s1_smp[p].u);
      prod_nxt[p][3] = mul16(s1_smp[p].i, ud);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
    end else begin
      s2_valid_r <= s1_ctrl.valid;
      s2_last_r  <= s1_ctrl.last;
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int k = 0; k < 4; k++) begin
        sum_nxt[p][k] = acc_r[p][k] + sext_prod(prod_r[p][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (s2_valid_r) begin
      if (s2_last_r) begin
        acc_r <= '0;
      end else begin
        acc_r <= sum_nxt;
      end
    end
  end

  assign res_valid = s2_valid_r && s2_last_r;

  always_comb begin
    for (int p = 0; p < NUM_PHASES; p++) begin
      res[p].cur_sq  = sum_nxt[p][0][RESULT_SHIFT +: SQ_OUT_W];
      res[p].volt_sq = sum_nxt[p][1][RESULT_SHIFT +: SQ_OUT_W];
      res[p].act     = sum_nxt[p][2][RESULT_SHIFT +: PWR_OUT_W];
      res[p].react   = sum_nxt[p][3][RESULT_SHIFT +: PWR_OUT_W];
    end
  end

endmodule

FILE: rtl/tppa_out_buf.sv
// ----------------------------------------------------------------------------
// Three-phase power accumulator: result buffer
// Holds the three phase results of one cycle and hands them out in phase
// order, one item per accepted handshake.
// ----------------------------------------------------------------------------
module tppa_out_buf import tppa_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_valid,
  input  phase_res_t [NUM_PHASES-1:0] res,
  output logic                        busy,
  tppa_out_if.source                  out_ch
);

  phase_res_t [NUM_PHASES-1:0] buf_r;
  logic                        busy_r;
  logic [PHASE_W-1:0]          idx_r;
  logic                        out_fire;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign busy     = busy_r;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      buf_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (res_valid) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_fire) begin
      if (idx_r == LAST_PHASE) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign out_ch.valid              = busy_r;
  assign out_ch.phase_index        = idx_r;
  assign out_ch.current_square_sum = buf_r[idx_r].cur_sq;
  assign out_ch.voltage_square_sum = buf_r[idx_r].volt_sq;
  assign out_ch.active_power_sum   = buf_r[idx_r].act;
  assign out_ch.reactive_power_sum = buf_r[idx_r].react;
  assign out_ch.last_of_cycle      = (idx_r == LAST_PHASE);

endmodule

FILE: rtl/three_phase_power_accumulator_core.sv
// ----------------------------------------------------------------------------
// Three-phase power accumulator: top level
// Takes one sample set per item (current and voltage of phases A, B, C),
// removes the DC offsets and accumulates per phase I^2, U^2, I*U and I times
// the voltage from a quarter cycle back. After every 1024 items it emits
// three result items, phases A, B, C, the last one marked last_of_cycle.
//
// Channels: in_ch takes sample items, out_ch gives result items, cfg_ch
// writes the six offset registers (always ready; unknown indexes ignored).
// Throughput: one item per cycle unless in_ch.ready is held low. Results of a cycle
// go out one per handshake once its closing item has reached the result buffer.
// The delay line is a single memory of 256 rows, read and written at the
// same row once per item; a fill flag stands in for clearing it.
// Reset clears offsets, sums, counters and the fill flag; no clearing pass.
// A stalled receiver holds the results; the block keeps taking items until
// the item that closes the next cycle arrives while results still wait,
// and holds that item off until the last result has gone.
// ----------------------------------------------------------------------------
module three_phase_power_accumulator_core import tppa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tppa_in_if.sink    in_ch,
  tppa_out_if.source out_ch,
  tppa_cfg_if.sink   cfg_ch
);

  sample_t                        offs_r [CFG_NUM_REGS];
  logic [POS_W-1:0]               pos_r;
  logic [DLY_AW-1:0]              ptr_r;
  logic                           primed_r;
  logic                           in_fire;
  logic                           at_last;
  logic                           obuf_busy;
  phase_smp_t [NUM_PHASES-1:0]    smp_nxt;
  phase_smp_t [NUM_PHASES-1:0]    s1_smp_r;
  s1_ctrl_t                       s1_ctrl_r;
  logic [NUM_PHASES*SAMPLE_W-1:0] dly_wdata;
  logic [NUM_PHASES*SAMPLE_W-1:0] dly_rdata;
  logic                           res_valid;
  phase_res_t [NUM_PHASES-1:0]    res;

  // Offset registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CFG_NUM_REGS; k++) begin
        offs_r[k] <= '0;
      end
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_OFFSET_CURRENT_A: offs_r[0] <= cfg_ch.data;
        CFG_OFFSET_VOLTAGE_A: offs_r[1] <= cfg_ch.data;
        CFG_OFFSET_CURRENT_B: offs_r[2] <= cfg_ch.data;
        CFG_OFFSET_VOLTAGE_B: offs_r[3] <= cfg_ch.data;
        CFG_OFFSET_CURRENT_C: offs_r[4] <= cfg_ch.data;
        CFG_OFFSET_VOLTAGE_C: offs_r[5] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input side: hold the closing item while the previous results still wait
  assign at_last     = (pos_r == LAST_POS);
  assign in_ch.ready = !(at_last && obuf_busy);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    smp_nxt[0].i = sample_t'(in_ch.current_a - offs_r[0]);
    smp_nxt[0].u = sample_t'(in_ch.voltage_a - offs_r[1]);
    smp_nxt[1].i = sample_t'(in_ch.current_b - offs_r[2]);
    smp_nxt[1].u = sample_t'(in_ch.voltage_b - offs_r[3]);
    smp_nxt[2].i = sample_t'(in_ch.current_c - offs_r[4]);
    smp_nxt[2].u = sample_t'(in_ch.voltage_c - offs_r[5]);
    for (int p = 0; p < NUM_PHASES; p++) begin
      dly_wdata[p*SAMPLE_W +: SAMPLE_W] = smp_nxt[p].u;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ptr_r    <= '0;
      primed_r <= 1'b0;
    end else if (in_fire) begin
      pos_r <= at_last ? '0 : pos_r + 1'b1;
      if (ptr_r == LAST_PTR) begin
        ptr_r    <= '0;
        primed_r <= 1'b1;
      end else begin
        ptr_r <= ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_smp_r <= smp_nxt;
    if (!rst_n) begin
      s1_ctrl_r <= '0;
    end else begin
      s1_ctrl_r.valid  <= in_fire;
      s1_ctrl_r.last   <= at_last;
      s1_ctrl_r.primed <= primed_r;
    end
  end

  tppa_delay_mem u_delay_mem (
    .clk     (clk),
    .en      (in_fire),
    .addr    (ptr_r),
    .wdata   (dly_wdata),
    .rdata_r (dly_rdata)
  );

  tppa_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_ctrl   (s1_ctrl_r),
    .s1_smp    (s1_smp_r),
    .dly_rdata (dly_rdata),
    .res_valid (res_valid),
    .res       (res)
  );

  tppa_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .busy      (obuf_busy),
    .out_ch    (out_ch)
  );

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Three-phase power accumulator: self-checking bench
// Drives sample sets and offset writes into the core and predicts the per-phase
// cycle sums on the side. A short table of directed sets opens the run: full
// cycles at the sample extremes, with the resulting sums typed in, then single
// mixed sets. Random phases follow, each with its own offset setting, with
// bursts of idling on both channels and one long result hold-off that makes the
// core stall its input. Every result item is checked field by field.
// ----------------------------------------------------------------------------
module testbench import tppa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES   = 12;
  localparam int STALL_LIMIT     = 10000;
  localparam int HOLD_OFF_CYCLES = 2600;
  localparam int PRESSURE_ITEMS  = 3000;
  localparam int RANDOM_PHASES   = 9;
  localparam int PRESSURE_PHASE  = 4;
  localparam int SPARE_PHASE     = 2;
  localparam int LAST_PHASE_NUM  = RANDOM_PHASES - 1;

  // Indexes beyond the register file; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CUR_REG [NUM_PHASES] =
    '{CFG_OFFSET_CURRENT_A, CFG_OFFSET_CURRENT_B, CFG_OFFSET_CURRENT_C};
  localparam logic [CFG_IDX_W-1:0] VOLT_REG [NUM_PHASES] =
    '{CFG_OFFSET_VOLTAGE_A, CFG_OFFSET_VOLTAGE_B, CFG_OFFSET_VOLTAGE_C};

  localparam int SUM_CUR_SQ   = 0;
  localparam int SUM_VOLT_SQ  = 1;
  localparam int SUM_ACTIVE   = 2;
  localparam int SUM_REACTIVE = 3;
  localparam int NUM_SUMS     = 4;

  localparam sample_t     S_MIN = 16'sh8000;
  localparam sample_t     S_MAX = 16'sh7FFF;
  localparam logic [15:0] FULL  = 16'(SAMPLES_PER_CYCLE);
  localparam logic [15:0] ONCE  = 16'd1;

  typedef struct packed {
    sample_t                     cur_a;
    sample_t                     volt_a;
    sample_t                     cur_b;
    sample_t                     volt_b;
    sample_t                     cur_c;
    sample_t                     volt_c;
    logic [15:0]                 reps;
    logic                        typed;
    logic [SQ_OUT_W-1:0]         cur_sq;
    logic [SQ_OUT_W-1:0]         volt_sq;
    logic signed [PWR_OUT_W-1:0] active;
    logic signed [PWR_OUT_W-1:0] reactive;
  } stim_row_t;

  typedef struct packed {
    logic [PHASE_W-1:0]          phase;
    logic [SQ_OUT_W-1:0]         cur_sq;
    logic [SQ_OUT_W-1:0]         volt_sq;
    logic signed [PWR_OUT_W-1:0] active;
    logic signed [PWR_OUT_W-1:0] reactive;
    logic                        last;
  } phase_sums_t;

  // Full-cycle rows start at reset with zero offsets; their sums are typed in.
  // The first reads a delay line still empty, the third reads voltages left
  // behind by the previous cycle.
  localparam stim_row_t DIRECTED [10] = '{
    '{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, FULL, 1'b1,
      31'd1073741824, 31'd1073741824, 32'sd1073741824, 32'sd805306368},
    '{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, FULL, 1'b1,
      31'd1073676289, 31'd1073741824, -32'sd1073709056, -32'sd1073709056},
    '{S_MAX, 16'sd0, S_MAX, 16'sd0, S_MAX, 16'sd0, FULL, 1'b1,
      31'd1073676289, 31'd0, 32'sd0, -32'sd268427264},
    '{S_MAX, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, ONCE, 1'b0,
      31'd0, 31'd0, 32'sd0, 32'sd0},
    '{-16'sd1, -16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd1, ONCE, 1'b0,
      31'd0, 31'd0, 32'sd0, 32'sd0},
    '{16'sd21845, -16'sd21846, -16'sd21846, 16'sd21845, 16'sd0, S_MIN, ONCE, 1'b0,
      31'd0, 31'd0, 32'sd0, 32'sd0},
    '{16'sd0, S_MIN, S_MIN, 16'sd0, 16'sd1, S_MAX, ONCE, 1'b0,
      31'd0, 31'd0, 32'sd0, 32'sd0},
    '{16'sd256, -16'sd256, 16'sd4096, 16'sd8192, -16'sd16384, 16'sd16383, ONCE, 1'b0,
      31'd0, 31'd0, 32'sd0, 32'sd0},
    '{S_MIN, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, ONCE, 1'b0,
      31'd0, 31'd0, 32'sd0, 32'sd0},
    '{16'sd1, 16'sd0, -16'sd1, 16'sd0, 16'sd0, -16'sd1, ONCE, 1'b0,
      31'd0, 31'd0, 32'sd0, 32'sd0}
  };

  logic clk;
  logic rst_n = 1'b0;

  tppa_in_if  in_ch ();
  tppa_out_if out_ch ();
  tppa_cfg_if cfg_ch ();

  three_phase_power_accumulator_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state
  sample_t     offsets [CFG_NUM_REGS];
  sample_t     volt_history [NUM_PHASES][QUARTER_DELAY];
  int          hist_ptr;
  int          cycle_pos;
  longint      phase_acc [NUM_PHASES][NUM_SUMS];
  phase_sums_t closing_sums [NUM_PHASES];
  phase_sums_t pending_sums [$];

  int fail_count       = 0;
  int tx_stretch       = 0;
  bit tx_idling        = 1'b0;
  bit pressure_on      = 1'b0;
  bit final_stretch    = 1'b0;
  bit hold_off_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Fold one sample set into the running sums; close the cycle when it is full.
  task automatic meter_sample_set(input stim_row_t row, output bit closed);
    sample_t            raw_cur [NUM_PHASES];
    sample_t            raw_volt [NUM_PHASES];
    sample_t            cur;
    sample_t            volt;
    sample_t            lagged;
    logic signed [63:0] q;
    int                 p;
    int                 s;
    raw_cur  = '{row.cur_a, row.cur_b, row.cur_c};
    raw_volt = '{row.volt_a, row.volt_b, row.volt_c};
    closed   = 1'b0;
    for (p = 0; p < NUM_PHASES; p++) begin
      // Offset removal wraps to 16 bits.
      cur    = raw_cur[p] - offsets[CUR_REG[p]];
      volt   = raw_volt[p] - offsets[VOLT_REG[p]];
      lagged = volt_history[p][hist_ptr];
      volt_history[p][hist_ptr] = volt;
      phase_acc[p][SUM_CUR_SQ]   += longint'(cur) * longint'(cur);
      phase_acc[p][SUM_VOLT_SQ]  += longint'(volt) * longint'(volt);
      phase_acc[p][SUM_ACTIVE]   += longint'(cur) * longint'(volt);
      phase_acc[p][SUM_REACTIVE] += longint'(cur) * longint'(lagged);
    end
    hist_ptr = (hist_ptr + 1) % QUARTER_DELAY;
    cycle_pos++;
    if (cycle_pos == SAMPLES_PER_CYCLE) begin
      cycle_pos = 0;
      closed    = 1'b1;
      for (p = 0; p < NUM_PHASES; p++) begin
        closing_sums[p].phase    = PHASE_W'(p);
        q = phase_acc[p][SUM_CUR_SQ] >>> RESULT_SHIFT;
        closing_sums[p].cur_sq   = q[SQ_OUT_W-1:0];
        q = phase_acc[p][SUM_VOLT_SQ] >>> RESULT_SHIFT;
        closing_sums[p].volt_sq  = q[SQ_OUT_W-1:0];
        q = phase_acc[p][SUM_ACTIVE] >>> RESULT_SHIFT;
        closing_sums[p].active   = q[PWR_OUT_W-1:0];
        q = phase_acc[p][SUM_REACTIVE] >>> RESULT_SHIFT;
        closing_sums[p].reactive = q[PWR_OUT_W-1:0];
        closing_sums[p].last     = (p == NUM_PHASES - 1);
        for (s = 0; s < NUM_SUMS; s++) phase_acc[p][s] = 0;
      end
    end
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MIN;
      1: return S_MAX;
      2: return sample_t'($urandom_range(0, 16)) - 16'sd8;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic stim_row_t random_set();
    stim_row_t row;
    row        = '0;
    row.cur_a  = pick_sample();
    row.volt_a = pick_sample();
    row.cur_b  = pick_sample();
    row.volt_b = pick_sample();
    row.cur_c  = pick_sample();
    row.volt_c = pick_sample();
    row.reps   = ONCE;
    return row;
  endfunction

  // Offer one sample set, wait for it to be taken, then predict.
  task automatic offer_set(input stim_row_t row);
    bit          closed;
    phase_sums_t due;
    int          p;
    if (tx_stretch == 0) begin
      tx_idling  = $urandom_range(0, 1);
      tx_stretch = $urandom_range(40, 300);
    end
    tx_stretch--;
    if (tx_idling && !pressure_on && !final_stretch && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.current_a <= row.cur_a;
    in_ch.voltage_a <= row.volt_a;
    in_ch.current_b <= row.cur_b;
    in_ch.voltage_b <= row.volt_b;
    in_ch.current_c <= row.cur_c;
    in_ch.voltage_c <= row.volt_c;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    meter_sample_set(row, closed);
    if (closed) begin
      for (p = 0; p < NUM_PHASES; p++) begin
        due = closing_sums[p];
        if (row.typed) begin
          due.cur_sq   = row.cur_sq;
          due.volt_sq  = row.volt_sq;
          due.active   = row.active;
          due.reactive = row.reactive;
        end
        pending_sums.push_back(due);
      end
    end
  endtask

  // Valid is left high; the caller drops it after the last write.
  task automatic write_offset(input logic [CFG_IDX_W-1:0] idx, input sample_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    if (idx < CFG_NUM_REGS) offsets[idx] = value;
  endtask

  // Stop offering, let every due result go, then give the pipeline time to empty.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    sample_t cur_off;
    sample_t volt_off;
    int      r;
    int      n;
    int      ph;
    int      p;
    int      k;
    int      phase_items;
    in_ch.valid     <= 1'b0;
    in_ch.current_a <= '0;
    in_ch.voltage_a <= '0;
    in_ch.current_b <= '0;
    in_ch.voltage_b <= '0;
    in_ch.current_c <= '0;
    in_ch.voltage_c <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    foreach (offsets[i]) offsets[i] = '0;
    foreach (volt_history[i, j]) volt_history[i][j] = '0;
    foreach (phase_acc[i, j]) phase_acc[i][j] = 0;
    hist_ptr  = 0;
    cycle_pos = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < $size(DIRECTED); r++) begin
      for (n = 0; n < DIRECTED[r].reps; n++) offer_set(DIRECTED[r]);
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiesce();
      for (p = 0; p < NUM_PHASES; p++) begin
        case (ph)
          0: begin
            cur_off  = S_MIN;
            volt_off = S_MAX;
          end
          1: begin
            cur_off  = S_MAX;
            volt_off = S_MIN;
          end
          3: begin
            cur_off  = sample_t'($urandom_range(0, 64)) - 16'sd32;
            volt_off = sample_t'($urandom_range(0, 64)) - 16'sd32;
          end
          LAST_PHASE_NUM: begin
            cur_off  = '0;
            volt_off = '0;
          end
          default: begin
            cur_off  = sample_t'($urandom);
            volt_off = sample_t'($urandom);
          end
        endcase
        write_offset(CUR_REG[p], cur_off);
        write_offset(VOLT_REG[p], volt_off);
      end
      if (ph == SPARE_PHASE) begin
        write_offset(CFG_SPARE_LO, sample_t'($urandom_range(1, 32767)));
        write_offset(CFG_SPARE_HI, S_MIN);
      end
      cfg_ch.valid <= 1'b0;

      pressure_on   = (ph == PRESSURE_PHASE);
      final_stretch = (ph == LAST_PHASE_NUM);
      if (pressure_on) hold_off_request = 1'b1;
      phase_items = pressure_on ? PRESSURE_ITEMS : $urandom_range(1100, 1600);
      // The closing phase runs on to a cycle boundary so its sums are seen too.
      for (k = 0; k < phase_items || (final_stretch && cycle_pos != 0); k++) begin
        offer_set(random_set());
      end
      pressure_on = 1'b0;
    end

    quiesce();
    if (fail_count == 0) begin
      $display("PASS three_phase_power_accumulator_core");
    end else begin
      $display("FAIL three_phase_power_accumulator_core");
    end
    $finish;
  end

  // Result side pacing: random stretches with and without idle bursts, plus
  // one long hold-off on request.
  initial begin : result_pacing
    int stretch;
    bit idling;
    stretch = 0;
    idling  = 1'b0;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        if (stretch == 0) begin
          idling  = $urandom_range(0, 1);
          stretch = $urandom_range(50, 400);
        end
        stretch--;
        if (idling && !final_stretch && $urandom_range(0, 4) == 0) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    phase_sums_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_sums.size() == 0) begin
        $error("result item with nothing due: phase_index %0d", out_ch.phase_index);
        fail_count++;
      end else begin
        want = pending_sums.pop_front();
        if (out_ch.phase_index !== want.phase) begin
          $error("phase_index: expected %0d, got %0d", want.phase, out_ch.phase_index);
          fail_count++;
        end
        if (out_ch.current_square_sum !== want.cur_sq) begin
          $error("current_square_sum: expected %0d, got %0d",
                 want.cur_sq, out_ch.current_square_sum);
          fail_count++;
        end
        if (out_ch.voltage_square_sum !== want.volt_sq) begin
          $error("voltage_square_sum: expected %0d, got %0d",
                 want.volt_sq, out_ch.voltage_square_sum);
          fail_count++;
        end
        if (out_ch.active_power_sum !== want.active) begin
          $error("active_power_sum: expected %0d, got %0d",
                 want.active, out_ch.active_power_sum);
          fail_count++;
        end
        if (out_ch.reactive_power_sum !== want.reactive) begin
          $error("reactive_power_sum: expected %0d, got %0d",
                 want.reactive, out_ch.reactive_power_sum);
          fail_count++;
        end
        if (out_ch.last_of_cycle !== want.last) begin
          $error("last_of_cycle: expected %0d, got %0d", want.last, out_ch.last_of_cycle);
          fail_count++;
        end
      end
    end
  end

  // Count cycles in which no channel moves an item; give up past the limit.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL three_phase_power_accumulator_core");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tppa_pkg.sv
rtl/tppa_if.sv
rtl/tppa_delay_mem.sv
rtl/tppa_mac.sv
rtl/tppa_out_buf.sv
rtl/three_phase_power_accumulator_core.sv
bench/testbench.sv
